[rtl/drof_pkg.sv]
// ----------------------------------------------------------------------------
// drof_pkg
// Shared types and constants for the dual-reader overwriting ring buffer.
// ----------------------------------------------------------------------------
package drof_pkg;

   localparam int DEPTH_DEFAULT        = 256;
   localparam int SAMPLE_WIDTH_DEFAULT = 64;

   localparam int DATA_WIDTH   = 64;
   localparam int LEVEL_WIDTH  = 8;
   localparam int THRESH_WIDTH = 8;
   localparam int CSR_IDX_WIDTH = 8;

   localparam logic [THRESH_WIDTH-1:0] A_THRESHOLD_RESET = 8'd10;
   localparam logic [THRESH_WIDTH-1:0] B_THRESHOLD_RESET = 8'd200;

   // operation codes
   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_READ_A = 2'd1;
   localparam logic [1:0] OP_READ_B = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_A_THRESHOLD = 8'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_B_THRESHOLD = 8'd1;

   typedef struct packed {
      logic [1:0]            opcode;
      logic [DATA_WIDTH-1:0] write_data;
   } drof_req_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0]  read_data;
      logic                   read_valid;
      logic                   dropped_a;
      logic                   dropped_b;
      logic [LEVEL_WIDTH-1:0] level_a;
      logic [LEVEL_WIDTH-1:0] level_b;
      logic                   ready_a;
      logic                   ready_b;
   } drof_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } drof_state_type;

   typedef struct packed {
      logic accept;       // item taken this cycle: update pointers, access store
      logic result_load;  // capture the result register
   } drof_cmd_type;

endpackage

[rtl/drof_ram.sv]
// ----------------------------------------------------------------------------
// drof_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module drof_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/drof_ctrl.sv]
// ----------------------------------------------------------------------------
// drof_ctrl
// Sequencer: accept one item, execute it, then present its result.
// ----------------------------------------------------------------------------
module drof_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output drof_pkg::drof_cmd_type cmd
);

   drof_pkg::drof_state_type state_ff;
   drof_pkg::drof_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= drof_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cmd.accept      = 1'b0;
      cmd.result_load = 1'b0;
      req_stall       = 1'b1;
      rsp_valid       = 1'b0;
      unique case (state_ff)
         drof_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = drof_pkg::ST_EXEC;
            end
         end
         drof_pkg::ST_EXEC: begin
            // store read data arrives now
            cmd.result_load = 1'b1;
            state_in        = drof_pkg::ST_RESP;
         end
         drof_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = drof_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = drof_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/drof_datapath.sv]
// ----------------------------------------------------------------------------
// drof_datapath
// Pointers, sample store, thresholds and the result register.
// ----------------------------------------------------------------------------
module drof_datapath #(
   parameter int DEPTH        = drof_pkg::DEPTH_DEFAULT,
   parameter int SAMPLE_WIDTH = drof_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  drof_pkg::drof_cmd_type                cmd,
   input  drof_pkg::drof_req_type                req_data,
   input  logic                                  csr_write,
   input  logic [drof_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  logic [drof_pkg::THRESH_WIDTH-1:0]     csr_wdata,
   output drof_pkg::drof_rsp_type                rsp_data
);

   localparam int PTR_WIDTH = $clog2(DEPTH);
   localparam logic [PTR_WIDTH-1:0] PTR_LAST = PTR_WIDTH'(DEPTH - 1);
   localparam logic [PTR_WIDTH:0]   DEPTH_EXT = (PTR_WIDTH + 1)'(DEPTH);

   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_a_ptr_ff, rd_a_ptr_in;
   logic [PTR_WIDTH-1:0] rd_b_ptr_ff, rd_b_ptr_in;
   logic [drof_pkg::THRESH_WIDTH-1:0] thr_a_ff, thr_b_ff;
   logic rvalid_ff, rvalid_in;
   logic drop_a_ff, drop_a_in;
   logic drop_b_ff, drop_b_in;
   drof_pkg::drof_rsp_type rsp_ff, rsp_in;

   logic                    ram_we;
   logic                    ram_re;
   logic [PTR_WIDTH-1:0]    ram_raddr;
   logic [SAMPLE_WIDTH-1:0] ram_rdata;
   logic [PTR_WIDTH-1:0]    wr_next;
   logic [PTR_WIDTH-1:0]    fill_a, fill_b;

   function automatic logic [PTR_WIDTH-1:0] ptr_next(input logic [PTR_WIDTH-1:0] p);
      ptr_next = (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_WIDTH-1:0] fill_of(input logic [PTR_WIDTH-1:0] w,
                                                     input logic [PTR_WIDTH-1:0] r);
      logic [PTR_WIDTH:0] diff;
      diff = {1'b0, w} - {1'b0, r};
      if (w < r) begin
         diff = diff + DEPTH_EXT;
      end
      fill_of = diff[PTR_WIDTH-1:0];
   endfunction

   assign wr_next = ptr_next(wr_ptr_ff);

   always_comb begin
      wr_ptr_in   = wr_ptr_ff;
      rd_a_ptr_in = rd_a_ptr_ff;
      rd_b_ptr_in = rd_b_ptr_ff;
      rvalid_in   = rvalid_ff;
      drop_a_in   = drop_a_ff;
      drop_b_in   = drop_b_ff;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      ram_raddr   = rd_a_ptr_ff;
      if (cmd.accept) begin
         rvalid_in = 1'b0;
         drop_a_in = 1'b0;
         drop_b_in = 1'b0;
         unique case (req_data.opcode)
            drof_pkg::OP_WRITE: begin
               ram_we    = 1'b1;
               wr_ptr_in = wr_next;
               // drop the oldest entry of any reader the writer catches up with
               if (wr_next == rd_a_ptr_ff) begin
                  rd_a_ptr_in = ptr_next(rd_a_ptr_ff);
                  drop_a_in   = 1'b1;
               end
               if (wr_next == rd_b_ptr_ff) begin
                  rd_b_ptr_in = ptr_next(rd_b_ptr_ff);
                  drop_b_in   = 1'b1;
               end
            end
            drof_pkg::OP_READ_A: begin
               if (rd_a_ptr_ff != wr_ptr_ff) begin
                  ram_re      = 1'b1;
                  ram_raddr   = rd_a_ptr_ff;
                  rd_a_ptr_in = ptr_next(rd_a_ptr_ff);
                  rvalid_in   = 1'b1;
               end
            end
            drof_pkg::OP_READ_B: begin
               if (rd_b_ptr_ff != wr_ptr_ff) begin
                  ram_re      = 1'b1;
                  ram_raddr   = rd_b_ptr_ff;
                  rd_b_ptr_in = ptr_next(rd_b_ptr_ff);
                  rvalid_in   = 1'b1;
               end
            end
            default: begin
               // unused opcode: pointers and store stay unchanged
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_a_ptr_ff <= '0;
         rd_b_ptr_ff <= '0;
         rvalid_ff   <= 1'b0;
         drop_a_ff   <= 1'b0;
         drop_b_ff   <= 1'b0;
      end else begin
         wr_ptr_ff   <= wr_ptr_in;
         rd_a_ptr_ff <= rd_a_ptr_in;
         rd_b_ptr_ff <= rd_b_ptr_in;
         rvalid_ff   <= rvalid_in;
         drop_a_ff   <= drop_a_in;
         drop_b_ff   <= drop_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_a_ff <= drof_pkg::A_THRESHOLD_RESET;
         thr_b_ff <= drof_pkg::B_THRESHOLD_RESET;
      end else if (csr_write) begin
         if (csr_index == drof_pkg::CSR_A_THRESHOLD) begin
            thr_a_ff <= csr_wdata;
         end
         if (csr_index == drof_pkg::CSR_B_THRESHOLD) begin
            thr_b_ff <= csr_wdata;
         end
      end
   end

   drof_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_data.write_data[SAMPLE_WIDTH-1:0]),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // pointers already hold their post-step values here
   assign fill_a = fill_of(wr_ptr_ff, rd_a_ptr_ff);
   assign fill_b = fill_of(wr_ptr_ff, rd_b_ptr_ff);

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.result_load) begin
         rsp_in.read_data  = rvalid_ff ? drof_pkg::DATA_WIDTH'(ram_rdata) : '0;
         rsp_in.read_valid = rvalid_ff;
         rsp_in.dropped_a  = drop_a_ff;
         rsp_in.dropped_b  = drop_b_ff;
         rsp_in.level_a    = drof_pkg::LEVEL_WIDTH'(fill_a);
         rsp_in.level_b    = drof_pkg::LEVEL_WIDTH'(fill_b);
         rsp_in.ready_a    = (fill_a >= thr_a_ff);
         rsp_in.ready_b    = (fill_b >= thr_b_ff);
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

[rtl/dual_reader_overwrite_fifo.sv]
// ----------------------------------------------------------------------------
// dual_reader_overwrite_fifo
// Ring buffer with one writer and two readers; writes overwrite the oldest
// entry of any reader that would be overtaken.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one operation per item (write, read for A, read for B).
//   rsp_* returns one result per item: read data, drop flags, both fill
//   levels and the threshold ready flags.
//   csr_* writes the reader thresholds (index 0: reader A, 1: reader B);
//   csr_ready is always high. Write only while no item is in flight.
// Timing:
//   An accepted item moves through ST_EXEC, where its result is captured,
//   to ST_RESP, where rsp_* presents it. One item is in flight at a time,
//   and its steps are: accept, store access (registered RAM read), result
//   handoff. req_stall is high from accept until the result is taken.
// Reset:
//   Pointers are cleared so both readers are empty; thresholds return to
//   10 and 200. The sample store is not cleared and needs no clearing pass.
// Stall:
//   While rsp_stall is high the result holds and no new item is accepted.
// ----------------------------------------------------------------------------
module dual_reader_overwrite_fifo #(
   parameter int DEPTH        = drof_pkg::DEPTH_DEFAULT,
   parameter int SAMPLE_WIDTH = drof_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  drof_pkg::drof_req_type             req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output drof_pkg::drof_rsp_type             rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [drof_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [drof_pkg::THRESH_WIDTH-1:0]  csr_wdata
);

   drof_pkg::drof_cmd_type cmd;

   assign csr_ready = 1'b1;

   drof_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   drof_datapath #(
      .DEPTH        (DEPTH),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_write (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

endmodule
